// ----- design/mdfhp_pkg.sv -----
// ----------------------------------------------------------------------------
// MAC data frame header parser package
// Shared types, field codes and the header layout function used by the
// parser datapath and its frame check.
// ----------------------------------------------------------------------------
package mdfhp_pkg;

	// Frame limits (buffer indices, PHY length byte at index 0)
	localparam logic [7:0] MIN_PHY_LEN = 8'd5;
	localparam logic [7:0] MAX_PHY_LEN = 8'd127;
	localparam logic [7:0] FCS_LEN     = 8'd2;
	localparam logic [7:0] HDR_START   = 8'd4;
	localparam logic [7:0] COUNT_MAX   = 8'd255;

	// Frame control codes
	localparam logic [2:0] FRAME_TYPE_DATA = 3'd1;
	localparam logic [1:0] VERSION_MAX     = 2'd1;

	// Address mode codes
	localparam logic [1:0] ADDR_NONE     = 2'd0;
	localparam logic [1:0] ADDR_RESERVED = 2'd1;
	localparam logic [1:0] ADDR_SHORT    = 2'd2;
	localparam logic [1:0] ADDR_EXT      = 2'd3;

	// Positions are at most 24, so five bits cover every layout
	typedef struct packed {
		logic [1:0] dmode;
		logic [1:0] smode;
		logic       comp;
		logic [4:0] span_at;   // source PAN low byte
		logic [4:0] saddr_at;  // first source address byte
		logic [4:0] end_at;    // just past the source address
	} layout_t;

	// Captured header state of the buffer in flight
	typedef struct packed {
		logic [7:0]  byte_count;
		logic [7:0]  frame_length;
		logic [15:0] control_word;
		logic [15:0] dest_pan;
		logic [15:0] src_pan;
		logic [63:0] src_addr;
		logic [4:0]  header_end;
	} hdr_state_t;

	// One parse result
	typedef struct packed {
		logic        frame_ok;
		logic [15:0] src_pan_id;
		logic [1:0]  src_mode;
		logic [63:0] src_address;
		logic [6:0]  payload_offset;
		logic [6:0]  payload_len;
	} result_t;

	// Address field length in bytes; reserved mode counts as empty
	function automatic logic [4:0] mode_len(input logic [1:0] m);
		logic [4:0] len;
		case (m)
			ADDR_SHORT: len = 5'd2;
			ADDR_EXT:   len = 5'd8;
			default:    len = 5'd0;
		endcase
		return len;
	endfunction

	// Work out where the PAN and address fields sit for a frame control word
	function automatic layout_t layout_of(input logic [15:0] cw);
		layout_t    l;
		logic [4:0] pos;
		l.dmode = cw[11:10];
		l.smode = cw[15:14];
		l.comp  = cw[6];
		pos     = HDR_START[4:0];
		if (l.dmode != ADDR_NONE) begin
			pos = pos + 5'd2 + mode_len(l.dmode);
		end
		l.span_at = pos;
		if (!l.comp) begin
			pos = pos + 5'd2;
		end
		l.saddr_at = pos;
		l.end_at   = pos + mode_len(l.smode);
		return l;
	endfunction

endpackage

// ----- design/mdfhp_check.sv -----
// ----------------------------------------------------------------------------
// MAC data frame header parser - frame check
// Judges a completed buffer from its captured header state and builds the
// result, zeroed when the frame is rejected.
// ----------------------------------------------------------------------------
module mdfhp_check
	import mdfhp_pkg::*;
(
	input  hdr_state_t hdr,
	output result_t    res
);

	layout_t    lay;
	logic       ok;
	logic [7:0] hdr_end;
	logic [7:0] pay_len;

	assign lay     = layout_of(hdr.control_word);
	assign hdr_end = {3'b000, hdr.header_end};
	// L + 1 - FCS - header end
	assign pay_len = hdr.frame_length + 8'd1 - FCS_LEN - hdr_end;

	// Acceptance rules
	always_comb begin
		ok = (hdr.frame_length >= MIN_PHY_LEN)
			&& (hdr.frame_length <= MAX_PHY_LEN)
			&& ({1'b0, hdr.byte_count} >= ({1'b0, hdr.frame_length} + 9'd1))
			&& (hdr.control_word[2:0] == FRAME_TYPE_DATA)
			&& !hdr.control_word[3]
			&& !hdr.control_word[8]
			&& (hdr.control_word[13:12] <= VERSION_MAX)
			&& (lay.dmode != ADDR_RESERVED)
			&& (lay.smode != ADDR_RESERVED)
			&& (lay.smode != ADDR_NONE)
			&& !(lay.comp && (lay.dmode == ADDR_NONE))
			&& (hdr_end <= (hdr.frame_length - 8'd1));
	end

	// Result fields, all zero on reject
	always_comb begin
		res = '0;
		if (ok) begin
			res.frame_ok       = 1'b1;
			res.src_pan_id     = lay.comp ? hdr.dest_pan : hdr.src_pan;
			res.src_mode       = lay.smode;
			res.src_address    = hdr.src_addr;
			res.payload_offset = hdr_end[6:0];
			res.payload_len    = pay_len[6:0];
		end
	end

endmodule

// ----- design/mac_data_frame_header_parser.sv -----
// ----------------------------------------------------------------------------
// MAC data frame header parser - top level
// Byte-wide IEEE 802.15.4 data frame header decoder with one result per
// buffer.
// ----------------------------------------------------------------------------
// Takes one buffer byte per cycle while data_ready is high, starting with the
// PHY length byte, and gives exactly one result transaction on the byte marked
// last_byte. Each byte is held in an input register, during which the header
// capture and, on the last byte, the frame check run as short combinational
// logic into the result register; a byte can be accepted every cycle unless the
// input is stalled, and a result is offered once its last byte moves on from the input register.
// A held result stalls the input only once a further last byte reaches the
// input register. The parser returns to its cleared state after every last
// byte.
module mac_data_frame_header_parser
	import mdfhp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        frame_ok,
	output logic [15:0] src_pan_id,
	output logic [1:0]  src_mode,
	output logic [63:0] src_address,
	output logic [6:0]  payload_offset,
	output logic [6:0]  payload_len
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;

	hdr_state_t hdr_q;
	hdr_state_t hdr_next;
	layout_t    lay;
	layout_t    lay_new;
	logic [7:0] idx;
	logic [7:0] span_at;
	logic [7:0] saddr_at;
	logic [7:0] end_at;
	logic [7:0] addr_off;

	result_t    res;
	result_t    res_q;
	logic       res_valid_q;

	// Handshake: the input stage moves on unless a result is blocked
	assign advance    = valid_s1 && (!last_s1 || !res_valid_q || result_ready);
	assign data_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ready) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && data_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Field layout from the stored and the freshly completed control word
	assign idx      = hdr_q.byte_count;
	assign lay      = layout_of(hdr_q.control_word);
	assign lay_new  = layout_of({byte_s1, hdr_q.control_word[7:0]});
	assign span_at  = {3'b000, lay.span_at};
	assign saddr_at = {3'b000, lay.saddr_at};
	assign end_at   = {3'b000, lay.end_at};
	assign addr_off = idx - saddr_at;

	// Header capture for the byte in the input register
	always_comb begin
		hdr_next = hdr_q;
		if (idx == 8'd0) begin
			hdr_next.frame_length = byte_s1;
		end else if (idx == 8'd1) begin
			hdr_next.control_word[7:0] = byte_s1;
		end else if (idx == 8'd2) begin
			hdr_next.control_word[15:8] = byte_s1;
			hdr_next.header_end         = lay_new.end_at;
		end else if ((idx >= HDR_START) && (idx <= hdr_q.frame_length)) begin
			// destination PAN at indices 4 and 5
			if ((lay.dmode != ADDR_NONE) && (idx < (HDR_START + 8'd2))) begin
				if (idx[0]) hdr_next.dest_pan[15:8] = byte_s1;
				else        hdr_next.dest_pan[7:0]  = byte_s1;
			end
			// source PAN always starts at an even index
			if (!lay.comp && (idx >= span_at) && (idx < (span_at + 8'd2))) begin
				if (idx[0]) hdr_next.src_pan[15:8] = byte_s1;
				else        hdr_next.src_pan[7:0]  = byte_s1;
			end
			// source address, wire byte order
			if ((idx >= saddr_at) && (idx < end_at)) begin
				for (int b = 0; b < 8; b++) begin
					if (addr_off[2:0] == b[2:0]) begin
						hdr_next.src_addr[8*b +: 8] = byte_s1;
					end
				end
			end
		end
		if (hdr_q.byte_count != COUNT_MAX) begin
			hdr_next.byte_count = hdr_q.byte_count + 8'd1;
		end
	end

	// Header state, cleared after every last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= '0;
		end else if (advance) begin
			hdr_q <= last_s1 ? '0 : hdr_next;
		end
	end

	mdfhp_check u_check (
		.hdr (hdr_next),
		.res (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= res;
		end
	end

	assign result_valid   = res_valid_q;
	assign frame_ok       = res_q.frame_ok;
	assign src_pan_id     = res_q.src_pan_id;
	assign src_mode       = res_q.src_mode;
	assign src_address    = res_q.src_address;
	assign payload_offset = res_q.payload_offset;
	assign payload_len    = res_q.payload_len;

endmodule

// ----- design/mdfhp_checker.sv -----
// ----------------------------------------------------------------------------
// MAC data frame header parser - port checker
// Concurrent checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mdfhp_checker
	import mdfhp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic        frame_ok,
	input logic [15:0] src_pan_id,
	input logic [1:0]  src_mode,
	input logic [63:0] src_address,
	input logic [6:0]  payload_offset,
	input logic [6:0]  payload_len
);

	// A stalled result transaction stays offered
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result transaction dropped while stalled");

	// A stalled result keeps its frame_ok, source PAN, source address and payload length
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(frame_ok) && $stable(src_pan_id)
			&& $stable(src_address) && $stable(payload_len))
		else $error("result payload changed while stalled");

	// Rejected frames carry zero fields
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !frame_ok |-> (src_pan_id == 16'd0) && (src_mode == ADDR_NONE)
			&& (src_address == 64'd0) && (payload_offset == 7'd0)
			&& (payload_len == 7'd0))
		else $error("rejected frame with non-zero fields");

	// Accepted frames: real source mode, header past the minimum, payload inside L
	a_accept_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_ok |-> ((src_mode == ADDR_SHORT) || (src_mode == ADDR_EXT))
			&& (payload_offset >= 7'd8)
			&& (({1'b0, payload_offset} + {1'b0, payload_len}) <= 8'd126))
		else $error("accepted frame with impossible layout");

	// Short addresses leave the upper address bytes clear
	a_short_addr: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_ok && (src_mode == ADDR_SHORT)
			|-> (src_address[63:16] == 48'd0))
		else $error("short source address with upper bytes set");

endmodule

bind mac_data_frame_header_parser mdfhp_checker u_mdfhp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.frame_ok       (frame_ok),
	.src_pan_id     (src_pan_id),
	.src_mode       (src_mode),
	.src_address    (src_address),
	.payload_offset (payload_offset),
	.payload_len    (payload_len)
);
